### sv/kbd_pkg.sv
// Shared types, constants and sizes for the keyboard report differencer.
package kbd_pkg;

  // Held-key slots kept between reports (legal range 1 to 16)
  localparam int KEY_SLOTS   = 6;
  // Key codes carried by one boot report
  localparam int REPORT_KEYS = 6;
  // Modifier bits in report byte 0
  localparam int MOD_BITS    = 8;

  // One scan step per modifier bit, per held slot and per report code
  localparam int STEPS  = MOD_BITS + KEY_SLOTS + REPORT_KEYS;
  localparam int STEP_W = $clog2(STEPS);
  localparam int SLOT_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int CODE_W = $clog2(REPORT_KEYS);
  localparam int MODB_W = $clog2(MOD_BITS);

  localparam logic [STEP_W-1:0] REL_BASE   = STEP_W'(MOD_BITS);
  localparam logic [STEP_W-1:0] PRESS_BASE = STEP_W'(MOD_BITS + KEY_SLOTS);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(STEPS - 1);

  // Event kinds
  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Input transaction: one boot-keyboard report
  typedef struct packed {
    logic [7:0]  modifier_bits;
    logic [7:0]  key_code_0;
    logic [7:0]  key_code_1;
    logic [7:0]  key_code_2;
    logic [7:0]  key_code_3;
    logic [7:0]  key_code_4;
    logic [7:0]  key_code_5;
    logic [7:0]  device_index;
    logic [31:0] timestamp;
  } report_t;

  // Output transaction: one key event
  typedef struct packed {
    logic        event_kind;
    logic [7:0]  source_device;
    logic [7:0]  key_id;
    logic [31:0] event_time;
    logic        last_of_run;
  } key_event_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;
    logic              step;
    logic              flush;
    logic [STEP_W-1:0] step_idx;
  } kbd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic out_free;
  } kbd_sts_t;

endpackage

### sv/kbd_ctrl.sv
// Sequencer: loads a report, walks the scan steps, then flushes the last event.
module kbd_ctrl import kbd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     rpt_valid,
  output logic     rpt_stall,
  input  kbd_sts_t sts,
  output kbd_cmd_t cmd
);

  ctrl_state_t       state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic              advance;

  // A step stalls only when it must push the pending event into a full output
  assign advance = !(sts.hit && sts.pend_valid && !sts.out_free);

  // Next state and step counter
  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    case (state)
      ST_IDLE: begin
        step_cnt_next = '0;
        if (rpt_valid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          if (step_cnt == LAST_STEP) begin
            state_next = ST_FLUSH;
          end else begin
            step_cnt_next = step_cnt + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid || sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd          = '0;
    cmd.step_idx = step_cnt;
    rpt_stall    = 1'b1;
    case (state)
      ST_IDLE: begin
        rpt_stall = 1'b0;
        cmd.load  = rpt_valid;
      end
      ST_RUN: begin
        cmd.step = advance;
      end
      ST_FLUSH: begin
        cmd.flush = sts.pend_valid && sts.out_free;
      end
      default: rpt_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

### sv/kbd_dpath.sv
// Report registers, held-key slots, pending event and output register.
module kbd_dpath import kbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  report_t    rpt,
  input  kbd_cmd_t   cmd,
  output kbd_sts_t   sts,
  output logic       evt_valid,
  input  logic       evt_stall,
  output key_event_t evt
);

  // Captured report
  logic [7:0]  mods_r;
  logic [7:0]  changed;
  logic [7:0]  codes [REPORT_KEYS];
  logic [7:0]  dev;
  logic [31:0] tstamp;

  // Persistent state
  logic [7:0]  prior_mods;
  logic [7:0]  held [KEY_SLOTS];

  // Event waiting to learn whether it is the last of its run
  logic        pend_valid;
  logic        pend_kind;
  logic [7:0]  pend_id;

  // Step decode
  logic [STEP_W-1:0] rel, prs;
  logic [SLOT_W-1:0] slot;
  logic [CODE_W-1:0] cidx;
  logic [MODB_W-1:0] mbit;
  logic [7:0]        hkey, ckey;
  logic              in_rpt, is_held, free_found;
  logic [SLOT_W-1:0] free_idx;
  logic              rel_phase, prs_phase;
  logic              hit, kind;
  logic [7:0]        id;
  logic              push, out_free;

  assign rel  = cmd.step_idx - REL_BASE;
  assign prs  = cmd.step_idx - PRESS_BASE;
  assign slot = rel[SLOT_W-1:0];
  assign cidx = prs[CODE_W-1:0];
  assign mbit = cmd.step_idx[MODB_W-1:0];
  assign hkey = held[slot];
  assign ckey = codes[cidx];

  assign rel_phase = (cmd.step_idx >= REL_BASE) && (cmd.step_idx < PRESS_BASE);
  assign prs_phase = (cmd.step_idx >= PRESS_BASE);

  // Membership tests and first empty slot
  always_comb begin
    in_rpt     = 1'b0;
    is_held    = 1'b0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = 0; j < REPORT_KEYS; j++) begin
      if (codes[j] == hkey) in_rpt = 1'b1;
    end
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (held[j] == ckey) is_held = 1'b1;
      if (!free_found && held[j] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(j);
      end
    end
  end

  // Candidate event for this step
  always_comb begin
    if (prs_phase) begin
      hit  = (ckey != 8'd0) && !is_held;
      kind = KIND_PRESS;
      id   = ckey;
    end else if (rel_phase) begin
      hit  = (hkey != 8'd0) && !in_rpt;
      kind = KIND_RELEASE;
      id   = hkey;
    end else begin
      hit  = changed[mbit];
      kind = mods_r[mbit] ? KIND_PRESS : KIND_RELEASE;
      id   = 8'(mbit);
    end
  end

  assign out_free = !evt_valid || !evt_stall;
  assign push     = (cmd.step && hit && pend_valid) || cmd.flush;

  assign sts.hit        = hit;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = out_free;

  // Report capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mods_r   <= rpt.modifier_bits;
      changed  <= rpt.modifier_bits ^ prior_mods;
      codes[0] <= rpt.key_code_0;
      codes[1] <= rpt.key_code_1;
      codes[2] <= rpt.key_code_2;
      codes[3] <= rpt.key_code_3;
      codes[4] <= rpt.key_code_4;
      codes[5] <= rpt.key_code_5;
      dev      <= rpt.device_index;
      tstamp   <= rpt.timestamp;
    end
  end

  // Modifier history and held slots
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_mods <= '0;
      for (int j = 0; j < KEY_SLOTS; j++) held[j] <= '0;
    end else begin
      if (cmd.load) begin
        prior_mods <= rpt.modifier_bits;
      end
      if (cmd.step && hit) begin
        if (prs_phase) begin
          if (free_found) held[free_idx] <= ckey;
        end else if (rel_phase) begin
          held[slot] <= 8'd0;
        end
      end
    end
  end

  // Pending event
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.step && hit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && hit) begin
      pend_kind <= kind;
      pend_id   <= id;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (push) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      evt.event_kind    <= pend_kind;
      evt.source_device <= dev;
      evt.key_id        <= pend_id;
      evt.event_time    <= tstamp;
      evt.last_of_run   <= cmd.flush;
    end
  end

endmodule

### sv/keyboard_report_diff_events.sv
// Top level of the keyboard report differencer: sequencer plus datapath.
//
//   channel  valid      stall      payload  dir
//   report   rpt_valid  rpt_stall  rpt      in
//   event    evt_valid  evt_stall  evt      out
//
// A report is taken, then scanned in MOD_BITS + KEY_SLOTS + REPORT_KEYS
// steps (20 by default) and a final flush step. Each event waits in a pending
// register until the next event or the flush step, so that last_of_run can be
// set on the final one. rst clears the modifier history, the held slots and
// all valid flags. A stall on the event side holds the scan only when a new
// event must move the pending one into a still-occupied output register; the
// flush step likewise waits until the pending event can move.
module keyboard_report_diff_events import kbd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rpt_valid,
  output logic       rpt_stall,
  input  report_t    rpt,
  output logic       evt_valid,
  input  logic       evt_stall,
  output key_event_t evt
);

  kbd_cmd_t cmd;
  kbd_sts_t sts;

  kbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kbd_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .rpt       (rpt),
    .cmd       (cmd),
    .sts       (sts),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  // A new report never finds an event left over from the previous one
  a_load_no_pend: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !sts.pend_valid)
    else $error("report loaded with a pending event");

  // A scan step never moves the pending event into an occupied output
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && sts.hit && sts.pend_valid) |-> sts.out_free)
    else $error("event pushed into an occupied output register");

  // After a flush nothing is left pending and the final event is in the output
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !sts.pend_valid && evt_valid && evt.last_of_run)
    else $error("flush did not deliver the final event");

  // Load, step and flush are mutually exclusive
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.load, cmd.step, cmd.flush}) <= 1)
    else $error("overlapping sequencer commands");

endmodule

### bench/tb_top.sv
// Self-checking testbench for keyboard_report_diff_events: predicted key events vs. DUT output.
module tb_top import kbd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          DRAIN_TAIL  = 3 * STEPS;
  localparam int          HOLD_CYCLES = 300;
  localparam int          PRINT_CAP   = 200;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rpt_valid = 1'b0;
  logic       rpt_stall;
  report_t    rpt = '0;
  logic       evt_valid;
  logic       evt_stall = 1'b0;
  key_event_t evt;

  keyboard_report_diff_events u_dut (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_stall (rpt_stall),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the differencer state
  logic [7:0] shadow_mods;
  logic [7:0] shadow_held [KEY_SLOTS];
  key_event_t pending_events [$];
  report_t    last_report;

  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          reports_sent = 0;
  int          events_checked = 0;
  int unsigned cycle_count = 0;
  logic        hold_active = 1'b0;
  event        hold_go;

  initial begin
    shadow_mods = '0;
    foreach (shadow_held[s]) shadow_held[s] = '0;
    last_report = '0;
  end

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic key_event_t make_event(logic kind, logic [7:0] id, report_t r);
    key_event_t ev;
    ev.event_kind    = kind;
    ev.source_device = r.device_index;
    ev.key_id        = id;
    ev.event_time    = r.timestamp;
    ev.last_of_run   = 1'b0;
    return ev;
  endfunction

  // Work out the events one report causes and advance the shadow state
  task automatic diff_report(report_t r);
    logic [7:0] codes [REPORT_KEYS];
    logic [7:0] changed;
    key_event_t batch [$];
    bit         found;
    bit         stored;
    codes[0] = r.key_code_0;
    codes[1] = r.key_code_1;
    codes[2] = r.key_code_2;
    codes[3] = r.key_code_3;
    codes[4] = r.key_code_4;
    codes[5] = r.key_code_5;

    // modifier bit changes, low bit first
    changed = r.modifier_bits ^ shadow_mods;
    for (int b = 0; b < MOD_BITS; b++) begin
      if (changed[b])
        batch.push_back(make_event(r.modifier_bits[b] ? KIND_PRESS : KIND_RELEASE,
                                   8'(b), r));
    end
    shadow_mods = r.modifier_bits;

    // held codes missing from the report are released and their slot freed
    for (int s = 0; s < KEY_SLOTS; s++) begin
      if (shadow_held[s] != 8'd0) begin
        found = 1'b0;
        for (int i = 0; i < REPORT_KEYS; i++)
          if (codes[i] == shadow_held[s]) found = 1'b1;
        if (!found) begin
          batch.push_back(make_event(KIND_RELEASE, shadow_held[s], r));
          shadow_held[s] = 8'd0;
        end
      end
    end

    // new codes in report order; stored in first free slot if any
    for (int i = 0; i < REPORT_KEYS; i++) begin
      if (codes[i] != 8'd0) begin
        found = 1'b0;
        for (int s = 0; s < KEY_SLOTS; s++)
          if (shadow_held[s] == codes[i]) found = 1'b1;
        if (!found) begin
          batch.push_back(make_event(KIND_PRESS, codes[i], r));
          stored = 1'b0;
          for (int s = 0; s < KEY_SLOTS; s++) begin
            if (!stored && shadow_held[s] == 8'd0) begin
              shadow_held[s] = codes[i];
              stored = 1'b1;
            end
          end
        end
      end
    end

    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[k]) pending_events.push_back(batch[k]);
  endtask

  // Offer one report, with an optional idle gap first, and predict on acceptance
  task automatic send_report(report_t r);
    int gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      rpt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rpt       <= r;
    rpt_valid <= 1'b1;
    do @(posedge clk); while (rpt_stall);
    diff_report(r);
    last_report = r;
    reports_sent++;
  endtask

  // Sender pauses until every predicted event is out, then lets the block settle
  task automatic wait_all_events();
    rpt_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic report_t mk_report(logic [7:0] mods, logic [7:0] c0, logic [7:0] c1,
                                        logic [7:0] c2, logic [7:0] c3, logic [7:0] c4,
                                        logic [7:0] c5, logic [7:0] dev, logic [31:0] ts);
    report_t r;
    r.modifier_bits = mods;
    r.key_code_0    = c0;
    r.key_code_1    = c1;
    r.key_code_2    = c2;
    r.key_code_3    = c3;
    r.key_code_4    = c4;
    r.key_code_5    = c5;
    r.device_index  = dev;
    r.timestamp     = ts;
    return r;
  endfunction

  // Mostly realistic typing: small edits of the previous report, plus noise
  function automatic report_t next_random_report();
    logic [7:0] k [REPORT_KEYS];
    logic [7:0] mods;
    int         roll;
    int         pick;
    roll = $urandom_range(99);
    k[0] = last_report.key_code_0;
    k[1] = last_report.key_code_1;
    k[2] = last_report.key_code_2;
    k[3] = last_report.key_code_3;
    k[4] = last_report.key_code_4;
    k[5] = last_report.key_code_5;
    mods = last_report.modifier_bits;
    if (roll < 70) begin
      for (int i = 0; i < REPORT_KEYS; i++) begin
        pick = $urandom_range(99);
        if (pick < 15)      k[i] = 8'd0;
        else if (pick < 40) k[i] = 8'($urandom_range(4, 40));
      end
      if ($urandom_range(1)) mods[$urandom_range(7)] ^= 1'b1;
      if ($urandom_range(3) == 0) mods[$urandom_range(7)] ^= 1'b1;
    end else if (roll < 85) begin
      foreach (k[i]) k[i] = 8'($urandom);
      mods = 8'($urandom);
    end else if (roll < 92) begin
      // identical keys and modifiers: nothing to report
    end else begin
      foreach (k[i]) k[i] = 8'd0;
      mods = 8'($urandom);
    end
    return mk_report(mods, k[0], k[1], k[2], k[3], k[4], k[5], 8'($urandom), $urandom);
  endfunction

  // Compare one accepted event with the oldest prediction
  task automatic check_event(key_event_t got);
    key_event_t want;
    if (pending_events.size() == 0) begin
      log_mismatch($sformatf("unexpected event kind=%0d key=%0h dev=%0h",
                             got.event_kind, got.key_id, got.source_device));
      return;
    end
    want = pending_events.pop_front();
    events_checked++;
    if (got.event_kind !== want.event_kind)
      log_mismatch($sformatf("event_kind %0b, want %0b", got.event_kind, want.event_kind));
    if (got.source_device !== want.source_device)
      log_mismatch($sformatf("source_device %0h, want %0h",
                             got.source_device, want.source_device));
    if (got.key_id !== want.key_id)
      log_mismatch($sformatf("key_id %0h, want %0h", got.key_id, want.key_id));
    if (got.event_time !== want.event_time)
      log_mismatch($sformatf("event_time %0h, want %0h", got.event_time, want.event_time));
    if (got.last_of_run !== want.last_of_run)
      log_mismatch($sformatf("last_of_run %0b, want %0b (key %0h)",
                             got.last_of_run, want.last_of_run, want.key_id));
  endtask

  // Event receiver: check, then pick next stall
  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) check_event(evt);
    if (hold_active) evt_stall <= 1'b1;
    else             evt_stall <= ($urandom_range(99) < stall_pct);
  end

  // Long output hold-off, counted here
  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TIMEOUT after %0d cycles, %0d events outstanding",
             cycle_count, pending_events.size());
    $display("** keyboard_report_diff_events: FAILED **");
    $finish;
  end

  // Field extremes, max event count, duplicates, reserved codes, unchanged reports
  task automatic test_directed();
    gap_pct   = 0;
    stall_pct = 0;
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0));
    send_report(mk_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
                          32'hFFFF_FFFF));
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 32'h1));
    send_report(mk_report(8'hA5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h80,
                          32'h8000_0000));
    // all 8 modifiers flip, all 6 slots released, 6 new presses
    send_report(mk_report(8'h5A, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h7F,
                          32'h7FFF_FFFF));
    send_report(mk_report(8'h5A, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F, 8'h12,
                          32'h1234_5678));
    send_report(mk_report(8'h5A, 8'h0F, 8'h0E, 8'h0D, 8'h00, 8'h00, 8'h00, 8'h33, 32'h55));
    // duplicate code in one report
    send_report(mk_report(8'h5A, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h00, 8'h0F, 8'h44, 32'h56));
    send_report(mk_report(8'h00, 8'hFF, 8'hFE, 8'h80, 8'h7F, 8'h01, 8'h02, 8'hAA,
                          32'hAAAA_AAAA));
    // rollover-error codes are plain key codes
    send_report(mk_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h55,
                          32'h5555_5555));
    send_report(mk_report(8'h01, 8'h00, 8'h05, 8'h00, 8'h06, 8'h00, 8'h07, 8'h02, 32'h100));
    send_report(mk_report(8'h80, 8'h00, 8'h05, 8'h00, 8'h06, 8'h00, 8'h07, 8'h03, 32'h101));
    send_report(mk_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 32'h102));
    send_report(mk_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE, 32'hFFFF));
    send_report(mk_report(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFD, 32'h1_0000));
    send_report(mk_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0));
    wait_all_events();
  endtask

  task automatic test_random_traffic(int send_idle, int recv_stall, int count);
    gap_pct   = send_idle;
    stall_pct = recv_stall;
    repeat (count) send_report(next_random_report());
    wait_all_events();
  endtask

  // Output held off while reports keep coming, so the input side backs up
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    -> hold_go;
    repeat (12)
      send_report(mk_report(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                            $urandom));
    wait_all_events();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(0, 0, 80);
    test_backpressure();
    test_random_traffic(62, 0, 80);
    test_random_traffic(0, 62, 80);
    test_random_traffic(26, 26, 80);
    $display("Ran %0d reports, checked %0d events over directed, random and held-off phases",
             reports_sent, events_checked);
    $display("Sender gaps and receiver stalls at 0, 26 and 62 percent; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("** keyboard_report_diff_events: PASSED **");
    end else begin
      $display("** keyboard_report_diff_events: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/kbd_pkg.sv
sv/kbd_ctrl.sv
sv/kbd_dpath.sv
sv/keyboard_report_diff_events.sv
bench/tb_top.sv
